/* hw/rtl/spiral_pattern_pixel_generator_assert.svh */
// assertion macros used by the spiral generator top level
`ifndef SPIRAL_PATTERN_PIXEL_GENERATOR_ASSERT_SVH
`define SPIRAL_PATTERN_PIXEL_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPPG_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/sppg_pkg.sv */
// shared constants and tables of the spiral pixel generator
package sppg_pkg;
	localparam int CORDIC_STEPS = 28;
	localparam int CENTER_BITS = 16;
	localparam int DELTA_BITS = CENTER_BITS + 1;
	localparam int DSQ_BITS = 2 * CENTER_BITS + 2;
	localparam int DIST_BITS = 25;
	localparam int TURN_FRAC = 32;
	localparam int T_BITS = 17;
	localparam int W_BITS = 17;
	localparam int TWIST_BITS = 24;
	localparam int THICK3_BITS = 10;

	// atan(2^-i) in 2^-32 turn units
	localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
		30'd81, 30'd41, 30'd20, 30'd10, 30'd5
	};

	localparam logic [31:0] CORDIC_INV_GAIN = 32'd652032874;

	typedef enum logic [2:0] {
		REG_COLORS_A,
		REG_COLORS_B,
		REG_FIFTH_BG,
		REG_CENTER,
		REG_ARM_COUNT,
		REG_TWIST,
		REG_THICKNESS,
		REG_MODE
	} cfg_reg_t;
endpackage

/* hw/rtl/sppg_delay.sv */
// enabled delay line for data that rides beside the arithmetic units
module sppg_delay import sppg_pkg::*; #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] line_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_s[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				line_s[k] <= line_s[k-1];
			end
		end
	end

	assign q = line_s[DEPTH-1];
endmodule

/* hw/rtl/sppg_sqrt.sv */
// pipelined distance: floor(sqrt((dx^2 + dy^2) * 2^16)), one root bit per stage
module sppg_sqrt import sppg_pkg::*; (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DELTA_BITS-1:0] dx,
	input  logic signed [DELTA_BITS-1:0] dy,
	output logic [DIST_BITS-1:0]         radius
);
	localparam int RAD_BITS = 2 * DIST_BITS;
	localparam int REM_BITS = DIST_BITS + 2;

	logic signed [DSQ_BITS-1:0] dx_sq, dy_sq;
	logic [DSQ_BITS-1:0] dsq;
	logic [RAD_BITS-1:0] rad_s [DIST_BITS+1];
	logic [REM_BITS-1:0] rem_s [DIST_BITS+1];
	logic [DIST_BITS-1:0] root_s [DIST_BITS+1];

	assign dx_sq = dx * dx;
	assign dy_sq = dy * dy;
	assign dsq = unsigned'(dx_sq) + unsigned'(dy_sq);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0] <= {dsq, {(RAD_BITS-DSQ_BITS){1'b0}}};
			rem_s[0] <= '0;
			root_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < DIST_BITS; i++) begin : g_bit
		logic [REM_BITS+1:0] cur, trial, diff;

		assign cur = {rem_s[i], rad_s[i][RAD_BITS-1 -: 2]};
		assign trial = {{(REM_BITS-DIST_BITS){1'b0}}, root_s[i], 2'b01};
		assign diff = cur - trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i+1] <= rad_s[i] << 2;
				if (cur >= trial) begin
					rem_s[i+1] <= diff[REM_BITS-1:0];
					root_s[i+1] <= {root_s[i][DIST_BITS-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= cur[REM_BITS-1:0];
					root_s[i+1] <= {root_s[i][DIST_BITS-2:0], 1'b0};
				end
			end
		end
	end

	assign radius = root_s[DIST_BITS];
endmodule

/* hw/rtl/sppg_atan.sv */
// pipelined vectoring cordic: angle of (dx, dy) as a fraction of a turn
module sppg_atan import sppg_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [DELTA_BITS-1:0] dx,
	input  logic signed [DELTA_BITS-1:0] dy,
	output logic [ANGLE_BITS-1:0]        angle
);
	localparam int XY_BITS = DELTA_BITS + 13;
	localparam int Z_BITS = TURN_FRAC + 2;
	localparam logic signed [Z_BITS-1:0] Z_HALF =
		{{(Z_BITS-TURN_FRAC){1'b0}}, 1'b1, {(TURN_FRAC-1){1'b0}}};
	localparam logic [TURN_FRAC-1:0] ROUND_HALF = TURN_FRAC'(1) << (31 - ANGLE_BITS);

	logic signed [XY_BITS-1:0] x_in, y_in;
	logic signed [XY_BITS-1:0] x_s [CORDIC_STEPS+1];
	logic signed [XY_BITS-1:0] y_s [CORDIC_STEPS+1];
	logic signed [Z_BITS-1:0] z_s [CORDIC_STEPS+1];
	logic zero_s [CORDIC_STEPS+1];
	logic [TURN_FRAC-1:0] z_round;

	assign x_in = XY_BITS'(dx) <<< 8;
	assign y_in = XY_BITS'(dy) <<< 8;

	// fold the left half plane onto the right one
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (dx == '0) && (dy == '0);
			if (dx < 0) begin
				x_s[0] <= -x_in;
				y_s[0] <= -y_in;
				z_s[0] <= Z_HALF;
			end else begin
				x_s[0] <= x_in;
				y_s[0] <= y_in;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XY_BITS-1:0] xs, ys;
		logic signed [Z_BITS-1:0] step;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign step = $signed(Z_BITS'(ATAN_TURNS[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + step;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - step;
				end
			end
		end
	end

	// round half up, wrap into one turn
	assign z_round = z_s[CORDIC_STEPS][TURN_FRAC-1:0] + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= zero_s[CORDIC_STEPS] ? '0 : z_round[TURN_FRAC-1 -: ANGLE_BITS];
		end
	end
endmodule

/* hw/rtl/sppg_div.sv */
// pipelined restoring divide: ramp = floor(phase * 2^22 / (thick3 * 2^ANGLE_BITS))
module sppg_div import sppg_pkg::*; #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic [ANGLE_BITS-1:0]  phase,
	input  logic [THICK3_BITS-1:0] thick3,
	output logic [T_BITS-1:0]      ramp
);
	localparam int NUM_SHIFT = 22;
	localparam int RW = ANGLE_BITS + THICK3_BITS + T_BITS - 1;

	logic [RW-1:0] rem_s [T_BITS];
	logic [T_BITS-1:0] q_s [T_BITS];

	// quotient is exact only inside the shaded band, which is all that uses it
	for (genvar j = 0; j < T_BITS; j++) begin : g_bit
		logic [RW-1:0] cur_r, dk;
		logic [T_BITS-1:0] cur_q;

		if (j == 0) begin : g_first
			assign cur_r = RW'(phase) << NUM_SHIFT;
			assign cur_q = '0;
		end else begin : g_next
			assign cur_r = rem_s[j-1];
			assign cur_q = q_s[j-1];
		end

		assign dk = RW'(thick3) << (ANGLE_BITS + T_BITS - 1 - j);

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur_r >= dk) begin
					rem_s[j] <= cur_r - dk;
					q_s[j] <= cur_q | (T_BITS'(1) << (T_BITS - 1 - j));
				end else begin
					rem_s[j] <= cur_r;
					q_s[j] <= cur_q;
				end
			end
		end
	end

	assign ramp = q_s[T_BITS-1];
endmodule

/* hw/rtl/sppg_sin.sv */
// pipelined rotation cordic: weight = sin^2(ramp / 4 turn) in q16
module sppg_sin import sppg_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [T_BITS-1:0] ramp,
	output logic [W_BITS-1:0] weight
);
	localparam int XY_BITS = 33;
	localparam int Z_BITS = TURN_FRAC + 2;
	localparam int S_BITS = 31;
	localparam logic signed [XY_BITS-1:0] X_START = XY_BITS'(CORDIC_INV_GAIN);
	localparam logic signed [XY_BITS-1:0] Y_MAX = XY_BITS'(1) <<< 30;
	localparam logic [W_BITS-1:0] W_ONE = W_BITS'(1) << 16;

	logic signed [XY_BITS-1:0] x_s [CORDIC_STEPS];
	logic signed [XY_BITS-1:0] y_s [CORDIC_STEPS];
	logic signed [Z_BITS-1:0] z_s [CORDIC_STEPS];
	logic [S_BITS-1:0] mag_s;
	logic [2*S_BITS-1:0] mag_sq;
	logic [W_BITS:0] w_raw;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [XY_BITS-1:0] cx, cy, xs, ys;
		logic signed [Z_BITS-1:0] cz, step;

		if (i == 0) begin : g_first
			assign cx = X_START;
			assign cy = '0;
			assign cz = $signed(Z_BITS'(ramp) << 14);
		end else begin : g_next
			assign cx = x_s[i-1];
			assign cy = y_s[i-1];
			assign cz = z_s[i-1];
		end

		assign xs = cx >>> i;
		assign ys = cy >>> i;
		assign step = $signed(Z_BITS'(ATAN_TURNS[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cz[Z_BITS-1]) begin
					x_s[i] <= cx - ys;
					y_s[i] <= cy + xs;
					z_s[i] <= cz - step;
				end else begin
					x_s[i] <= cx + ys;
					y_s[i] <= cy - xs;
					z_s[i] <= cz + step;
				end
			end
		end
	end

	// clamp the sine to [0, 1]
	always_ff @(posedge clk) begin
		if (en) begin
			if (y_s[CORDIC_STEPS-1][XY_BITS-1]) begin
				mag_s <= '0;
			end else if (y_s[CORDIC_STEPS-1] > Y_MAX) begin
				mag_s <= S_BITS'(Y_MAX);
			end else begin
				mag_s <= y_s[CORDIC_STEPS-1][S_BITS-1:0];
			end
		end
	end

	assign mag_sq = mag_s * mag_s;
	assign w_raw = mag_sq[2*S_BITS-1 -: W_BITS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			weight <= (w_raw > {1'b0, W_ONE}) ? W_ONE : w_raw[W_BITS-1:0];
		end
	end
endmodule

/* hw/rtl/spiral_pattern_pixel_generator.sv */
// top level of the multi-arm spiral pixel generator
//
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  cfg     | cfg_write           | cfg_index, cfg_data
//  in      | in_valid / in_stall | pixel_x, pixel_y, last_in_tile
//  out     | out_valid/out_stall | red, green, blue, alpha, last_out
//
// one pixel item per clock while in_stall is low; the latency is set by the
// two 28-step cordic pipelines and the 17-stage divider in series.
// the pipeline moves as one; a skid register behind the output register lets
// it take one more item while the output is stalled, then in_stall rises.
// reset clears the valid bits and loads the register reset values.
module spiral_pattern_pixel_generator import sppg_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [2:0]            cfg_index,
	input  logic [63:0]           cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic                  last_in_tile,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue,
	output logic [7:0]            alpha,
	output logic                  last_out
);
	`include "spiral_pattern_pixel_generator_assert.svh"

	localparam int LAT_ATAN = CORDIC_STEPS + 2;
	localparam int LAT_SQRT = DIST_BITS + 1;
	localparam int LAT_DIV = T_BITS;
	localparam int LAT_SIN = CORDIC_STEPS + 2;
	localparam int NSTAGE = 1 + LAT_ATAN + 3 + LAT_DIV + LAT_SIN + 1;
	localparam int PH_WIDE = ANGLE_BITS + THICK3_BITS;
	localparam int PROD_BITS = DIST_BITS + TWIST_BITS;

	typedef struct packed {
		logic [31:0] color;
		logic [31:0] bg;
		logic        hard_on;
		logic        shade_in;
		logic        shade;
		logic        last;
	} side_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
		logic       last;
	} pix_t;

	function automatic logic [7:0] blend_ch(input logic [7:0] c, input logic [7:0] bgc,
			input logic [W_BITS-1:0] w, input logic [W_BITS-1:0] iw);
		logic [25:0] acc;
		acc = 26'(c) * 26'(w) + 26'(bgc) * 26'(iw) + 26'd32768;
		return acc[23:16];
	endfunction

	// configuration registers
	logic [63:0] colors_a_q, colors_b_q, fifth_bg_q;
	logic [31:0] center_q;
	logic [3:0] arms_q;
	logic [TWIST_BITS-1:0] twist_q;
	logic [7:0] thick_q;
	logic [1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_a_q <= '0;
			colors_b_q <= '0;
			fifth_bg_q <= '0;
			center_q <= '0;
			arms_q <= 4'd4;
			twist_q <= '0;
			thick_q <= 8'd160;
			mode_q <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_COLORS_A:  colors_a_q <= cfg_data;
				REG_COLORS_B:  colors_b_q <= cfg_data;
				REG_FIFTH_BG:  fifth_bg_q <= cfg_data;
				REG_CENTER:    center_q <= cfg_data[31:0];
				REG_ARM_COUNT: arms_q <= cfg_data[3:0];
				REG_TWIST:     twist_q <= cfg_data[TWIST_BITS-1:0];
				REG_THICKNESS: thick_q <= cfg_data[7:0];
				REG_MODE:      mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// pipeline control
	logic en;
	logic [NSTAGE-1:0] stage_vld_q;
	logic skid_vld_q, out_vld_q;
	pix_t skid_q, out_q;

	assign en = !skid_vld_q;
	assign in_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[NSTAGE-2:0], in_valid};
		end
	end

	// offsets from the center
	logic signed [DELTA_BITS-1:0] dx_s1, dy_s1;
	logic last_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({{(DELTA_BITS-COORD_BITS){1'b0}}, pixel_x})
				- $signed({1'b0, center_q[31:16]});
			dy_s1 <= $signed({{(DELTA_BITS-COORD_BITS){1'b0}}, pixel_y})
				- $signed({1'b0, center_q[15:0]});
			last_s1 <= last_in_tile;
		end
	end

	logic [ANGLE_BITS-1:0] ang_s31;
	logic [DIST_BITS-1:0] dist_s27, dist_s31;
	logic last_s31;

	sppg_atan #(.ANGLE_BITS(ANGLE_BITS)) u_atan (
		.clk(clk), .en(en), .dx(dx_s1), .dy(dy_s1), .angle(ang_s31)
	);

	sppg_sqrt u_sqrt (
		.clk(clk), .en(en), .dx(dx_s1), .dy(dy_s1), .radius(dist_s27)
	);

	sppg_delay #(.WIDTH(DIST_BITS), .DEPTH(LAT_ATAN - LAT_SQRT)) u_dist_dly (
		.clk(clk), .en(en), .d(dist_s27), .q(dist_s31)
	);

	sppg_delay #(.WIDTH(1), .DEPTH(LAT_ATAN)) u_last_dly (
		.clk(clk), .en(en), .d(last_s1), .q(last_s31)
	);

	// twist, arm phase, color slice
	logic [PROD_BITS-1:0] prod_s32;
	logic [ANGLE_BITS-1:0] ang_s32, total_s33, ph_s34;
	logic last_s32, last_s33, last_s34;
	logic [ANGLE_BITS-1:0] spd;
	logic [3:0] arms;
	logic [ANGLE_BITS+3:0] ph_full, ph10;
	logic [3:0] slice;
	logic [2:0] slot;
	logic [31:0] arm_col [5];
	logic [THICK3_BITS-1:0] thick3;
	side_t side_s35, side_s81;

	assign spd = prod_s32[31 -: ANGLE_BITS];
	assign arms = (arms_q == '0) ? 4'd1 : arms_q;
	assign ph_full = total_s33 * arms;
	assign ph10 = ph_s34 * 4'd10;
	assign slice = ph10[ANGLE_BITS+3 -: 4];
	assign slot = (slice >= 4'd5) ? 3'(slice - 4'd5) : slice[2:0];
	assign thick3 = THICK3_BITS'(thick_q) * THICK3_BITS'(3);

	assign arm_col[0] = colors_a_q[63:32];
	assign arm_col[1] = colors_a_q[31:0];
	assign arm_col[2] = colors_b_q[63:32];
	assign arm_col[3] = colors_b_q[31:0];
	assign arm_col[4] = fifth_bg_q[63:32];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s32 <= dist_s31 * twist_q;
			ang_s32 <= ang_s31;
			last_s32 <= last_s31;
			total_s33 <= mode_q[0] ? ang_s32 - spd : ang_s32 + spd;
			last_s33 <= last_s32;
			ph_s34 <= ph_full[ANGLE_BITS-1:0];
			last_s34 <= last_s33;
			side_s35.color <= arm_col[slot];
			side_s35.bg <= fifth_bg_q[31:0];
			side_s35.hard_on <= PH_WIDE'({ph_s34, 5'b0})
				<= PH_WIDE'({thick_q, {ANGLE_BITS{1'b0}}});
			side_s35.shade_in <= (thick_q != '0)
				&& (PH_WIDE'({ph_s34, 6'b0}) <= {thick3, {ANGLE_BITS{1'b0}}});
			side_s35.shade <= mode_q[1];
			side_s35.last <= last_s34;
		end
	end

	// cosine edge weight
	logic [T_BITS-1:0] ramp_s51;
	logic [W_BITS-1:0] w_s81, iw;

	sppg_div #(.ANGLE_BITS(ANGLE_BITS)) u_div (
		.clk(clk), .en(en), .phase(ph_s34), .thick3(thick3), .ramp(ramp_s51)
	);

	sppg_sin u_sin (
		.clk(clk), .en(en), .ramp(ramp_s51), .weight(w_s81)
	);

	sppg_delay #(.WIDTH($bits(side_t)), .DEPTH(LAT_DIV - 1 + LAT_SIN)) u_side_dly (
		.clk(clk), .en(en), .d(side_s35), .q(side_s81)
	);

	assign iw = W_BITS'(1 << 16) - w_s81;

	// final pixel
	pix_t pix_s82;

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s82.last <= side_s81.last;
			if (side_s81.shade && side_s81.shade_in) begin
				pix_s82.r <= blend_ch(side_s81.color[31:24], side_s81.bg[31:24], w_s81, iw);
				pix_s82.g <= blend_ch(side_s81.color[23:16], side_s81.bg[23:16], w_s81, iw);
				pix_s82.b <= blend_ch(side_s81.color[15:8], side_s81.bg[15:8], w_s81, iw);
				pix_s82.a <= 8'hff;
			end else if (!side_s81.shade && side_s81.hard_on) begin
				pix_s82.r <= side_s81.color[31:24];
				pix_s82.g <= side_s81.color[23:16];
				pix_s82.b <= side_s81.color[15:8];
				pix_s82.a <= 8'hff;
			end else begin
				pix_s82.r <= side_s81.bg[31:24];
				pix_s82.g <= side_s81.bg[23:16];
				pix_s82.b <= side_s81.bg[15:8];
				pix_s82.a <= side_s81.bg[7:0];
			end
		end
	end

	// output register with skid
	logic pipe_vld;

	assign pipe_vld = stage_vld_q[NSTAGE-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				out_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= pipe_vld;
			end
		end else if (pipe_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || !out_stall) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (pipe_vld) begin
				out_q <= pix_s82;
			end
		end else if (pipe_vld && en) begin
			skid_q <= pix_s82;
		end
	end

	assign out_valid = out_vld_q;
	assign red = out_q.r;
	assign green = out_q.g;
	assign blue = out_q.b;
	assign alpha = out_q.a;
	assign last_out = out_q.last;

	`SPPG_ASSERT_IMPL(a_skid_behind_out, skid_vld_q, out_vld_q,
		"skid holds an item while the output register is empty")
	`SPPG_ASSERT_NEXT(a_skid_holds, skid_vld_q && out_stall, skid_vld_q,
		"skid item lost while the output is stalled")
	`SPPG_ASSERT_NEXT(a_no_drop, pipe_vld && !skid_vld_q && out_vld_q && out_stall,
		skid_vld_q, "pipeline item dropped at a stalled output")
endmodule
